// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/rcfplw_pkg.sv -----
`default_nettype none

package rcfplw_pkg;

    typedef logic [2:0]         t_reg_idx;
    typedef logic signed [1:0]  t_sign;
    typedef logic [3:0]         t_ch_idx;
    typedef logic [10:0]        t_ch_val;

    localparam t_reg_idx REG_FRAME_HEAD    = 3'd0;
    localparam t_reg_idx REG_LINK_TIMEOUT  = 3'd1;
    localparam t_reg_idx REG_ROLL_SIGN     = 3'd2;
    localparam t_reg_idx REG_PITCH_SIGN    = 3'd3;
    localparam t_reg_idx REG_THROTTLE_SIGN = 3'd4;
    localparam t_reg_idx REG_YAW_SIGN      = 3'd5;

    localparam logic [7:0]  FRAME_HEAD_RESET   = 8'd170;
    localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd500;
    localparam t_sign       SIGN_RESET         = 2'sd1;

    localparam t_sign SIGN_ZERO = 2'b00;
    localparam t_sign SIGN_POS  = 2'b01;
    localparam t_sign SIGN_NEG2 = 2'b10;
    localparam t_sign SIGN_NEG  = 2'b11;

    localparam logic OP_BYTE      = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam int      CH_COUNT    = 10;
    localparam t_ch_idx CH_LAST_IDX = 4'd9;
    localparam int      STORE_N     = 16;

    localparam t_ch_val VAL_MIN = 11'd1000;
    localparam t_ch_val VAL_MID = 11'd1500;
    localparam t_ch_val VAL_MAX = 11'd2000;

    // |raw*sign| at or above full scale saturates at the span
    localparam logic [16:0] AXIS_FULL   = 17'd2047;
    localparam logic [8:0]  AXIS_SPAN   = 9'd500;
    // floor(a*500/2047) == (a*RECIP_MUL) >> RECIP_SHIFT for a < 2047
    localparam logic [30:0] RECIP_MUL   = 31'd1024501;
    localparam int          RECIP_SHIFT = 22;

    function automatic t_ch_val axis_value(input logic [7:0] lo, input logic [7:0] hi,
                                           input t_sign sg);
        logic signed [17:0] raw_ext;
        logic signed [17:0] prod_s;
        logic [16:0]        mag;
        logic [30:0]        prod;
        logic [8:0]         q;
        raw_ext = {{2{hi[7]}}, hi, lo};
        case (sg)
            SIGN_POS:  prod_s = raw_ext;
            SIGN_NEG:  prod_s = -raw_ext;
            SIGN_NEG2: prod_s = -(raw_ext <<< 1);
            default:   prod_s = '0;
        endcase
        mag  = prod_s[17] ? 17'(-prod_s) : prod_s[16:0];
        prod = 31'(mag[10:0]) * RECIP_MUL;
        if (mag >= AXIS_FULL) begin
            q = AXIS_SPAN;
        end else begin
            q = 9'(prod >> RECIP_SHIFT);
        end
        return prod_s[17] ? t_ch_val'(VAL_MID - 11'(q)) : t_ch_val'(VAL_MID + 11'(q));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rc_frame_parser_link_watchdog.sv -----
// Frame parser and link watchdog for a serial remote-control receiver.
// Input channel (i_valid/o_ready): one item per transfer, either a received
// byte or a time tick carrying the milliseconds since the previous tick.
// Output channel (o_valid/i_ready): a good frame gives ten channel results,
// channel 0 to 9, the last one flagged; a tick gives one status result.
// Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; the user
// must write it only while the block is idle, the block does not enforce it.
// Throughput: one input transfer per cycle. Bytes are taken back to back;
// the byte that closes a frame waits until the previous frame's results and
// any pending status have left, and a tick waits for its one-entry slot.
// A tick passes the input register, the status slot and the result register;
// a closing byte passes the input register, r_calc, the channel buffer and
// the result register, then one channel per cycle as the receiver takes them.
// When the receiver stalls, the output register holds and bytes keep flowing
// until a closing byte or a second tick has to wait.
// Reset clears the frame position, the link state (age set to the reset
// timeout, link not seen) and all pending results, and loads register
// defaults.
`default_nettype none

module rc_frame_parser_link_watchdog #(
    parameter int FRAME_BYTES = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_operation,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_elapsed_ms,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_kind,
    output rcfplw_pkg::t_ch_idx   o_channel_index,
    output rcfplw_pkg::t_ch_val   o_channel_value,
    output logic                  o_last,
    output logic                  o_link_alive,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  rcfplw_pkg::t_reg_idx  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    import rcfplw_pkg::*;

    localparam int               POS_W         = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_CHECK     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_STORE_END = POS_W'(STORE_N);

    // configuration
    logic [7:0]  r_frame_head;
    logic [15:0] r_timeout;
    t_sign       r_roll_sign;
    t_sign       r_pitch_sign;
    t_sign       r_throttle_sign;
    t_sign       r_yaw_sign;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_head    <= FRAME_HEAD_RESET;
            r_timeout       <= LINK_TIMEOUT_RESET;
            r_roll_sign     <= SIGN_RESET;
            r_pitch_sign    <= SIGN_RESET;
            r_throttle_sign <= SIGN_RESET;
            r_yaw_sign      <= SIGN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRAME_HEAD:    r_frame_head    <= i_cfg_data[7:0];
                REG_LINK_TIMEOUT:  r_timeout       <= i_cfg_data;
                REG_ROLL_SIGN:     r_roll_sign     <= i_cfg_data[1:0];
                REG_PITCH_SIGN:    r_pitch_sign    <= i_cfg_data[1:0];
                REG_THROTTLE_SIGN: r_throttle_sign <= i_cfg_data[1:0];
                REG_YAW_SIGN:      r_yaw_sign      <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;
    logic [15:0] r_in_el;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_rx_byte;
            r_in_el   <= i_elapsed_ms;
        end
    end

    // state
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_sum;
    logic [7:0]       r_store [STORE_N];
    logic [15:0]      r_age;
    logic             r_seen;
    logic             r_tk_valid;
    logic             r_tk_alive;
    logic             r_calc;
    logic             r_ch_busy;
    t_ch_idx          r_ch_idx;
    t_ch_val          r_ch_val [CH_COUNT];
    t_ch_val          ch_calc [CH_COUNT];
    logic             r_out_valid;
    logic             n_out_valid;

    logic        out_free;
    logic        ch_take;
    logic        tk_take;
    logic        is_tick;
    logic        at_last;
    logic        advance;
    logic        byte_go;
    logic        tick_go;
    logic [7:0]  sum_all;
    logic        frame_good;
    logic [16:0] age_sum;
    logic        link_live;
    logic        age_over;
    logic        tick_alive;

    assign out_free = !r_out_valid || i_ready;
    assign ch_take  = out_free && r_ch_busy;
    assign tk_take  = out_free && r_tk_valid && !r_ch_busy && !r_calc;

    assign is_tick = (r_in_op == OP_TICK);
    assign at_last = (r_pos == POS_LAST);
    assign advance = r_in_valid && (is_tick ? (!r_tk_valid || tk_take)
                                            : (!at_last || (!r_ch_busy && !r_calc && !r_tk_valid)));
    assign o_ready = !r_in_valid || advance;
    assign byte_go = advance && !is_tick;
    assign tick_go = advance && is_tick;

    assign sum_all    = 8'(r_sum + r_in_byte);
    assign frame_good = byte_go && at_last && (sum_all == r_store[0]);

    assign age_sum    = {1'b0, r_age} + {1'b0, r_in_el};
    assign link_live  = r_seen && (r_age < r_timeout);
    assign age_over   = age_sum >= {1'b0, r_timeout};
    assign tick_alive = link_live && !age_over;

    always_comb begin
        n_pos = r_pos;
        if (byte_go) begin
            if (r_pos == '0) begin
                n_pos = (r_in_byte == r_frame_head) ? POS_CHECK : '0;
            end else if (at_last) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_CHECK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // bytes 1..16 kept, byte 1 is the checksum
    always_ff @(posedge i_clk) begin
        if (byte_go && r_pos != '0 && r_pos <= POS_STORE_END) begin
            r_store[4'(r_pos - POS_CHECK)] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_go) begin
            if (r_pos == '0) begin
                r_sum <= r_in_byte;
            end else if (r_pos != POS_CHECK) begin
                r_sum <= sum_all;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age  <= LINK_TIMEOUT_RESET;
            r_seen <= 1'b0;
        end else if (frame_good) begin
            r_age  <= '0;
            r_seen <= 1'b1;
        end else if (tick_go && link_live) begin
            r_age <= age_over ? r_timeout : age_sum[15:0];
        end
    end

    // pending status result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk_valid <= 1'b0;
        end else if (tick_go) begin
            r_tk_valid <= 1'b1;
        end else if (tk_take) begin
            r_tk_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_tk_alive <= tick_alive;
        end
    end

    // channel values, store index is byte number minus one
    always_comb begin
        ch_calc[0] = axis_value(r_store[5], r_store[6], r_roll_sign);
        ch_calc[1] = axis_value(r_store[7], r_store[8], r_pitch_sign);
        ch_calc[2] = axis_value(r_store[3], r_store[4], r_throttle_sign);
        ch_calc[3] = axis_value(r_store[1], r_store[2], r_yaw_sign);
        ch_calc[4] = (r_store[15] != '0) ? VAL_MIN : VAL_MAX;
        if (r_store[13] != '0 && r_store[14] == '0) begin
            ch_calc[5] = VAL_MID;
        end else if (r_store[13] == '0 && r_store[14] != '0) begin
            ch_calc[5] = VAL_MAX;
        end else begin
            ch_calc[5] = VAL_MIN;
        end
        for (int i = 0; i < 4; i++) begin
            ch_calc[6 + i] = (r_store[9 + i] != '0) ? VAL_MAX : VAL_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calc    <= 1'b0;
            r_ch_busy <= 1'b0;
            r_ch_idx  <= '0;
        end else begin
            r_calc <= frame_good;
            if (r_calc) begin
                r_ch_busy <= 1'b1;
                r_ch_idx  <= '0;
            end else if (ch_take) begin
                if (r_ch_idx == CH_LAST_IDX) begin
                    r_ch_busy <= 1'b0;
                end
                r_ch_idx <= r_ch_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_calc) begin
            r_ch_val <= ch_calc;
        end else if (ch_take) begin
            for (int i = 0; i < CH_COUNT - 1; i++) begin
                r_ch_val[i] <= r_ch_val[i + 1];
            end
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = ch_take || tk_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ch_take) begin
            o_kind          <= KIND_CHANNEL;
            o_channel_index <= r_ch_idx;
            o_channel_value <= r_ch_val[0];
            o_last          <= (r_ch_idx == CH_LAST_IDX);
            o_link_alive    <= 1'b0;
        end else if (tk_take) begin
            o_kind          <= KIND_STATUS;
            o_channel_index <= '0;
            o_channel_value <= '0;
            o_last          <= 1'b1;
            o_link_alive    <= r_tk_alive;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/rcfplw_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module rcfplw_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  i_operation,
    input logic [7:0]            i_rx_byte,
    input logic [15:0]           i_elapsed_ms,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_kind,
    input rcfplw_pkg::t_ch_idx   o_channel_index,
    input rcfplw_pkg::t_ch_val   o_channel_value,
    input logic                  o_last,
    input logic                  o_link_alive,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input rcfplw_pkg::t_reg_idx  i_cfg_index,
    input logic [15:0]           i_cfg_data
);
    import rcfplw_pkg::*;

    // status results stand alone
    `ASSERT_CLK(a_status_shape, (o_valid && o_kind == KIND_STATUS) |-> (o_last && o_channel_index == '0 && o_channel_value == '0), "status result malformed")

    // channel values inside the clamp, no alive flag
    `ASSERT_CLK(a_channel_range, (o_valid && o_kind == KIND_CHANNEL) |-> (o_channel_value >= VAL_MIN && o_channel_value <= VAL_MAX && !o_link_alive), "channel value out of range")

    // a frame closes on its last channel
    `ASSERT_CLK(a_channel_last, (o_valid && o_kind == KIND_CHANNEL) |-> (o_last == (o_channel_index == CH_LAST_IDX)), "last flag on wrong channel")

    // channels of a frame follow each other in order
    `ASSERT_CLK(a_channel_order, $past(o_valid && i_ready && o_kind == KIND_CHANNEL && !o_last) |-> (o_valid && o_kind == KIND_CHANNEL && o_channel_index == $past(o_channel_index) + 4'd1), "channel sequence broken")

    `ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_valid, "result pending after reset")

endmodule

bind rc_frame_parser_link_watchdog rcfplw_checker u_rcfplw_checker (.*);

`default_nettype wire
